### hdl/xy_wormhole_mesh_router_top_macros.svh
// assertion helpers shared by the router modules
// they expect clk and arst_n in the scope of the module that uses them
`ifndef XY_WORMHOLE_MESH_ROUTER_TOP_MACROS_SVH
`define XY_WORMHOLE_MESH_ROUTER_TOP_MACROS_SVH

// same-cycle implication
`define XWR_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XWR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/xwr_pkg.sv
package xwr_pkg;

	localparam int unsigned FLIT_WIDTH = 16;
	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned NUM_PORTS  = 5;

	typedef logic [FLIT_WIDTH-1:0] flit_t;
	typedef logic [2:0]            port_t;
	typedef logic [1:0]            phase_t;

	// port codes
	localparam port_t PORT_EAST  = 3'd0;
	localparam port_t PORT_WEST  = 3'd1;
	localparam port_t PORT_NORTH = 3'd2;
	localparam port_t PORT_SOUTH = 3'd3;
	localparam port_t PORT_LOCAL = 3'd4;
	localparam port_t UNBOUND    = 3'd7;

	// packet phases
	localparam phase_t PH_HEADER = 2'd0;
	localparam phase_t PH_SIZE   = 2'd1;
	localparam phase_t PH_BODY   = 2'd2;

	// configuration register indexes
	localparam logic CFG_ROUTER_X = 1'b0;
	localparam logic CFG_ROUTER_Y = 1'b1;

	typedef struct packed {
		logic [4:0] arrive_mask;
		logic [15:0] flit_east_in;
		logic [15:0] flit_west_in;
		logic [15:0] flit_north_in;
		logic [15:0] flit_south_in;
		logic [15:0] flit_local_in;
		logic [4:0] downstream_full_mask;
	} req_t;

	typedef struct packed {
		logic [4:0] send_mask;
		logic [15:0] flit_east_out;
		logic [15:0] flit_west_out;
		logic [15:0] flit_north_out;
		logic [15:0] flit_south_out;
		logic [15:0] flit_local_out;
		logic [4:0] fifo_full_mask;
		logic [4:0] dropped_mask;
	} rsp_t;

	// per-port fifo status seen by the switch
	typedef struct packed {
		logic  nonempty;
		flit_t head;
	} fifo_stat_t;

endpackage

### hdl/xwr_port_fifo.sv
`include "xy_wormhole_mesh_router_top_macros.svh"

module xwr_port_fifo #(
	parameter int unsigned DEPTH = xwr_pkg::FIFO_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                pop,
	input  logic                push,
	input  xwr_pkg::flit_t      push_data,
	output xwr_pkg::fifo_stat_t stat,
	output logic                full_after,
	output logic                dropped
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned SW = CW + 1;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
	localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

	xwr_pkg::flit_t mem [DEPTH];

	logic [CW-1:0]  count_q;
	logic [AW-1:0]  head_q;
	xwr_pkg::flit_t rd_q;
	xwr_pkg::flit_t byp_data_q;
	logic           byp_q;

	logic           do_pop;
	logic           do_push;
	logic           at_cap;
	logic [CW-1:0]  count_pop;
	logic [CW-1:0]  count_next;
	logic [AW-1:0]  head_next;
	logic [SW-1:0]  tail_sum;
	logic [AW-1:0]  tail;

	// occupancy after the pop, then the arrival
	always_comb begin
		do_pop     = tick & pop;
		count_pop  = count_q - CW'(do_pop);
		at_cap     = (count_pop == DEPTH_C);
		do_push    = tick & push & ~at_cap;
		dropped    = tick & push & at_cap;
		count_next = count_pop + CW'(do_push);
		full_after = (count_next == DEPTH_C);
	end

	// head advance and write slot, both wrapping at the depth
	always_comb begin
		if (do_pop) begin
			head_next = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
		end else begin
			head_next = head_q;
		end
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= DEPTH_S) begin
			tail = AW'(tail_sum - DEPTH_S);
		end else begin
			tail = AW'(tail_sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			head_q  <= '0;
		end else if (tick) begin
			count_q <= count_next;
			head_q  <= head_next;
		end
	end

	// flit storage, head prefetched for the next request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[tail] <= push_data;
		end
		rd_q       <= mem[head_next];
		byp_q      <= do_push && (tail == head_next);
		byp_data_q <= push_data;
	end

	assign stat.nonempty = (count_q != '0);
	assign stat.head     = byp_q ? byp_data_q : rd_q;

	`XWR_ASSERT_NOW(a_pop_nonempty, tick && pop, count_q != '0, "pop from empty fifo")
	`XWR_ASSERT_NEXT(a_drop_full, dropped, count_q == DEPTH_C, "drop without full fifo")

endmodule

### hdl/xwr_switch.sv
`include "xy_wormhole_mesh_router_top_macros.svh"

module xwr_switch (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic [3:0]          router_x,
	input  logic [3:0]          router_y,
	input  xwr_pkg::fifo_stat_t stat [xwr_pkg::NUM_PORTS],
	input  logic [4:0]          dfull,
	output logic [4:0]          pop,
	output logic [4:0]          send_mask,
	output xwr_pkg::flit_t      flit_out [xwr_pkg::NUM_PORTS]
);

	localparam int unsigned NP = xwr_pkg::NUM_PORTS;

	logic [2:0]       rr_q;
	xwr_pkg::port_t   bound_q [NP];
	xwr_pkg::phase_t  phase_q [NP];
	xwr_pkg::flit_t   left_q [NP];

	xwr_pkg::port_t   bound_eff [NP];
	xwr_pkg::port_t   bound_next [NP];
	xwr_pkg::phase_t  phase_next [NP];
	xwr_pkg::flit_t   left_next [NP];
	xwr_pkg::flit_t   left_dec [NP];
	xwr_pkg::port_t   target;
	logic             taken;
	logic [4:0]       fwd;
	logic             bind_clash;
	logic             stray_bind;

	// xy order: x first, then y, then local
	function automatic xwr_pkg::port_t route_xy(
		input xwr_pkg::flit_t flit,
		input logic [3:0] rx,
		input logic [3:0] ry
	);
		logic [3:0] tx;
		logic [3:0] ty;
		tx = flit[7:4];
		ty = flit[3:0];
		if (rx != tx) begin
			return (rx > tx) ? xwr_pkg::PORT_WEST : xwr_pkg::PORT_EAST;
		end else if (ry != ty) begin
			return (ry > ty) ? xwr_pkg::PORT_SOUTH : xwr_pkg::PORT_NORTH;
		end
		return xwr_pkg::PORT_LOCAL;
	endfunction

	// routing of the round-robin port's head flit
	always_comb begin
		bound_eff = bound_q;
		target    = route_xy(stat[rr_q].head, router_x, router_y);
		taken     = 1'b0;
		for (int p = 0; p < NP; p++) begin
			if (bound_q[p] == target) begin
				taken = 1'b1;
			end
		end
		if (stat[rr_q].nonempty && bound_q[rr_q] == xwr_pkg::UNBOUND && !taken) begin
			bound_eff[rr_q] = target;
		end
	end

	// forwarding and crossbar
	always_comb begin
		for (int q = 0; q < NP; q++) begin
			flit_out[q]  = '0;
			send_mask[q] = 1'b0;
		end
		for (int p = 0; p < NP; p++) begin
			fwd[p] = 1'b0;
			if (bound_eff[p] < 3'd5 && stat[p].nonempty) begin
				fwd[p] = !dfull[bound_eff[p]];
			end
			for (int q = 0; q < NP; q++) begin
				if (fwd[p] && bound_eff[p] == 3'(q)) begin
					flit_out[q]  = flit_out[q] | stat[p].head;
					send_mask[q] = 1'b1;
				end
			end
		end
		pop = fwd;
	end

	// packet phase tracking and release
	always_comb begin
		for (int p = 0; p < NP; p++) begin
			bound_next[p] = bound_eff[p];
			phase_next[p] = phase_q[p];
			left_next[p]  = left_q[p];
			left_dec[p]   = left_q[p] - 1'b1;
			if (bound_q[p] != bound_eff[p]) begin
				phase_next[p] = xwr_pkg::PH_HEADER;
			end
			if (fwd[p]) begin
				case (phase_next[p])
					xwr_pkg::PH_HEADER: begin
						phase_next[p] = xwr_pkg::PH_SIZE;
					end
					xwr_pkg::PH_SIZE: begin
						left_next[p]  = stat[p].head;
						phase_next[p] = xwr_pkg::PH_BODY;
						if (stat[p].head == '0) begin
							bound_next[p] = xwr_pkg::UNBOUND;
							phase_next[p] = xwr_pkg::PH_HEADER;
						end
					end
					default: begin
						left_next[p] = left_dec[p];
						if (left_dec[p] == '0) begin
							bound_next[p] = xwr_pkg::UNBOUND;
							phase_next[p] = xwr_pkg::PH_HEADER;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= xwr_pkg::PORT_LOCAL;
			for (int p = 0; p < NP; p++) begin
				bound_q[p] <= xwr_pkg::UNBOUND;
				phase_q[p] <= xwr_pkg::PH_HEADER;
				left_q[p]  <= '0;
			end
		end else if (tick) begin
			rr_q <= (rr_q == xwr_pkg::PORT_LOCAL) ? xwr_pkg::PORT_EAST : rr_q + 1'b1;
			for (int p = 0; p < NP; p++) begin
				bound_q[p] <= bound_next[p];
				phase_q[p] <= phase_next[p];
				left_q[p]  <= left_next[p];
			end
		end
	end

	// binding sanity checks
	always_comb begin
		bind_clash = 1'b0;
		stray_bind = 1'b0;
		for (int p = 0; p < NP; p++) begin
			if (bound_q[p] > xwr_pkg::PORT_LOCAL && bound_q[p] != xwr_pkg::UNBOUND) begin
				stray_bind = 1'b1;
			end
			for (int r = p + 1; r < NP; r++) begin
				if (bound_q[p] == bound_q[r] && bound_q[p] != xwr_pkg::UNBOUND) begin
					bind_clash = 1'b1;
				end
			end
		end
	end

	`XWR_ASSERT_NOW(a_bind_unique, 1'b1, !bind_clash, "output bound to two inputs")
	`XWR_ASSERT_NOW(a_bind_valid, 1'b1, !stray_bind && rr_q <= xwr_pkg::PORT_LOCAL, "bad port code")

endmodule

### hdl/xy_wormhole_mesh_router_top.sv
// Five-port XY wormhole mesh router (east, west, north, south, local).
// Request channel (req_valid/req_ready/req_data) carries one tick: the arrival
// mask, one flit per input port and the downstream full mask. Each accepted
// request routes the round-robin port's head flit, forwards one flit on every
// bound input whose output is free, queues the arrivals and advances the
// pointer. The response channel (rsp_valid/rsp_ready/rsp_data) returns the
// send mask, the sent flits, the fifo full mask and the drop mask.
// The response is registered and is valid in the cycle after its request is
// accepted. Throughput: one request per cycle while rsp_ready is high; each
// input fifo memory has one write and one prefetch read port, and the head
// flit is prefetched into a register. The response register holds a result
// while rsp_ready is low; a new request is taken in the same cycle the held
// response leaves, otherwise req_ready stays low.
// Reset empties all fifos, unbinds every input and points the round-robin
// pointer at the local port; router_x/router_y reset to 0; the user must write
// them via cfg_we/cfg_index/cfg_data while the router is idle (not enforced).
`include "xy_wormhole_mesh_router_top_macros.svh"

module xy_wormhole_mesh_router_top #(
	parameter int unsigned FIFO_DEPTH = xwr_pkg::FIFO_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  xwr_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output xwr_pkg::rsp_t rsp_data,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [3:0]    cfg_data
);

	localparam int unsigned NP = xwr_pkg::NUM_PORTS;

	logic [3:0]          router_x_q;
	logic [3:0]          router_y_q;
	logic                rsp_valid_q;
	xwr_pkg::rsp_t       rsp_q;
	logic                tick;

	xwr_pkg::flit_t      flit_in [NP];
	xwr_pkg::fifo_stat_t stat [NP];
	xwr_pkg::flit_t      flit_out [NP];
	logic [4:0]          pop;
	logic [4:0]          send_mask;
	logic [4:0]          full_mask;
	logic [4:0]          drop_mask;
	xwr_pkg::rsp_t       rsp_next;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			router_x_q <= '0;
			router_y_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				xwr_pkg::CFG_ROUTER_X: router_x_q <= cfg_data;
				xwr_pkg::CFG_ROUTER_Y: router_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign tick      = req_valid && req_ready;

	assign flit_in[0] = req_data.flit_east_in;
	assign flit_in[1] = req_data.flit_west_in;
	assign flit_in[2] = req_data.flit_north_in;
	assign flit_in[3] = req_data.flit_south_in;
	assign flit_in[4] = req_data.flit_local_in;

	// input fifos
	for (genvar p = 0; p < NP; p++) begin : g_fifo
		xwr_port_fifo #(
			.DEPTH(FIFO_DEPTH)
		) u_fifo (
			.clk       (clk),
			.arst_n    (arst_n),
			.tick      (tick),
			.pop       (pop[p]),
			.push      (req_data.arrive_mask[p]),
			.push_data (flit_in[p]),
			.stat      (stat[p]),
			.full_after(full_mask[p]),
			.dropped   (drop_mask[p])
		);
	end

	// routing, binding and crossbar
	xwr_switch u_switch (
		.clk      (clk),
		.arst_n   (arst_n),
		.tick     (tick),
		.router_x (router_x_q),
		.router_y (router_y_q),
		.stat     (stat),
		.dfull    (req_data.downstream_full_mask),
		.pop      (pop),
		.send_mask(send_mask),
		.flit_out (flit_out)
	);

	always_comb begin
		rsp_next.send_mask      = send_mask;
		rsp_next.flit_east_out  = flit_out[0];
		rsp_next.flit_west_out  = flit_out[1];
		rsp_next.flit_north_out = flit_out[2];
		rsp_next.flit_south_out = flit_out[3];
		rsp_next.flit_local_out = flit_out[4];
		rsp_next.fifo_full_mask = full_mask;
		rsp_next.dropped_mask   = drop_mask;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (tick) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	`XWR_ASSERT_NEXT(a_rsp_follows, tick, rsp_valid_q, "accepted request left no response")

endmodule
